// ----- src/pcne_pkg.sv -----
package pcne_pkg;

    // header geometry
    localparam int HEADER_LEN = 21;
    localparam int POS_W      = 5;

    // phase codes, also given out as status
    localparam logic [2:0] PH_SEARCH = 3'd0;
    localparam logic [2:0] PH_LENGTH = 3'd1;
    localparam logic [2:0] PH_NAME   = 3'd2;
    localparam logic [2:0] PH_DONE   = 3'd3;
    localparam logic [2:0] PH_ERROR  = 3'd4;

    localparam logic [7:0] TERM_RESET = 8'h3f;

    // header byte patterns, first and second encoding
    localparam logic [7:0] HDR_FIRST [32] = '{
        8'h02, 8'h00, 8'h07, 8'h70, 8'h75, 8'h62, 8'h6c, 8'h69,
        8'h73, 8'h68, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h05, 8'h02, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };
    localparam logic [7:0] HDR_SECOND [32] = '{
        8'h06, 8'h00, 8'h07, 8'h70, 8'h75, 8'h62, 8'h6c, 8'h69,
        8'h73, 8'h68, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h01, 8'h06, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };
    // positions that are compared; the transaction id bytes are don't-care
    localparam logic [31:0] HDR_CARE = 32'h0018_07ff;

    function automatic logic [7:0] hdr_byte(input logic alt, input logic [POS_W-1:0] pos);
        hdr_byte = alt ? HDR_SECOND[pos] : HDR_FIRST[pos];
    endfunction

endpackage

// ----- src/publish_command_name_extractor.sv -----
// publish command name extractor
// input channel: one raw stream byte per word on byte_in, in_valid/in_ready.
// output channel: one result word for every input word, out_valid/out_ready,
// carrying status (phase after the byte), name_valid, name_byte, name_last
// and used_alt_encoding.
// the block looks for a 21-byte publish header in either encoding, then
// reads a big-endian 16-bit name length and gives out the name bytes;
// capture stops on the length or on the name_terminator byte.
// the result of a byte is registered and is on the output in the cycle after it is taken.
// throughput: one byte per cycle while the receiver takes the results; all work of a byte is done in the cycle it
// is taken and lands in the output register.
// in_ready is high while the output register is empty or being read, so a
// stalled receiver holds the result and stops input after one word.
// cfg_wr_en/cfg_wr_data write name_terminator, no read-back.
// reset: search phase, both matchers at position zero, terminator 63,
// output register empty.
module publish_command_name_extractor
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] byte_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] status,
    output logic       name_valid,
    output logic [7:0] name_byte,
    output logic       name_last,
    output logic       used_alt_encoding
);

    logic        in_fire;
    logic        match_en;
    logic        hit_first;
    logic        hit_second;
    logic        hit_any;

    logic [7:0]  term_reg;
    logic [2:0]  phase_reg,    phase_next;
    logic [1:0]  len_cnt_reg,  len_cnt_next;
    logic [1:0]  len_cnt_inc;
    logic [15:0] name_len_reg, name_len_next;
    logic [15:0] name_cnt_reg, name_cnt_next;
    logic        alt_reg,      alt_next;
    logic        valid_next;
    logic        last_next;
    logic [7:0]  byte_next;

    logic        out_valid_reg;
    logic [2:0]  status_reg;
    logic        name_valid_reg;
    logic [7:0]  name_byte_reg;
    logic        name_last_reg;
    logic        alt_out_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign match_en = in_fire && (phase_reg == pcne_pkg::PH_SEARCH);
    assign hit_any  = hit_first || hit_second;

    // header matchers, one per encoding
    pcne_matcher u_match_first
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .alt     (1'b0),
        .en      (match_en),
        .clr     (hit_any),
        .byte_in (byte_in),
        .hit     (hit_first)
    );

    pcne_matcher u_match_second
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .alt     (1'b1),
        .en      (match_en),
        .clr     (hit_any),
        .byte_in (byte_in),
        .hit     (hit_second)
    );

    // terminator register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            term_reg <= pcne_pkg::TERM_RESET;
        else if (cfg_wr_en)
            term_reg <= cfg_wr_data;
    end

    // phase and counter update for one byte
    always_comb
    begin
        phase_next    = phase_reg;
        len_cnt_next  = len_cnt_reg;
        name_len_next = name_len_reg;
        name_cnt_next = name_cnt_reg;
        alt_next      = alt_reg;
        valid_next    = 1'b0;
        last_next     = 1'b0;
        byte_next     = 8'h00;
        len_cnt_inc   = len_cnt_reg + 2'd1;
        case (phase_reg)
            pcne_pkg::PH_SEARCH:
            begin
                if (hit_any)
                begin
                    alt_next      = !hit_first;
                    len_cnt_next  = '0;
                    name_len_next = '0;
                    name_cnt_next = '0;
                    phase_next    = pcne_pkg::PH_LENGTH;
                end
            end
            pcne_pkg::PH_LENGTH:
            begin
                name_len_next = {name_len_reg[7:0], byte_in};
                len_cnt_next  = len_cnt_inc;
                if (len_cnt_inc >= 2'd2)
                begin
                    len_cnt_next = '0;
                    phase_next   = (name_len_next == 16'd0) ? pcne_pkg::PH_ERROR
                                                            : pcne_pkg::PH_NAME;
                end
            end
            pcne_pkg::PH_NAME:
            begin
                if (byte_in == term_reg)
                begin
                    last_next  = 1'b1;
                    phase_next = pcne_pkg::PH_DONE;
                end
                else
                begin
                    valid_next    = 1'b1;
                    byte_next     = byte_in;
                    name_cnt_next = name_cnt_reg + 16'd1;
                    if (name_cnt_next >= name_len_reg)
                    begin
                        last_next  = 1'b1;
                        phase_next = pcne_pkg::PH_DONE;
                    end
                end
            end
            pcne_pkg::PH_DONE:
            begin
                phase_next = pcne_pkg::PH_DONE;
            end
            default:
            begin
                phase_next = pcne_pkg::PH_ERROR;
            end
        endcase
    end

    // state registers, moved only by an accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= pcne_pkg::PH_SEARCH;
            len_cnt_reg  <= '0;
            name_len_reg <= '0;
            name_cnt_reg <= '0;
            alt_reg      <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg    <= phase_next;
            len_cnt_reg  <= len_cnt_next;
            name_len_reg <= name_len_next;
            name_cnt_reg <= name_cnt_next;
            alt_reg      <= alt_next;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            status_reg     <= phase_next;
            name_valid_reg <= valid_next;
            name_byte_reg  <= byte_next;
            name_last_reg  <= last_next;
            alt_out_reg    <= alt_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign name_valid        = name_valid_reg;
    assign name_byte         = name_byte_reg;
    assign name_last         = name_last_reg;
    assign used_alt_encoding = alt_out_reg;

    // status shown always matches the phase held inside
    a_status_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == phase_reg)
        else $error("status differs from phase");

    // name bytes only while in name or at its end
    a_valid_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && name_valid) |->
            (status == pcne_pkg::PH_NAME || status == pcne_pkg::PH_DONE))
        else $error("name byte outside name phase");

    // last word of a name always moves to done
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && name_last) |-> status == pcne_pkg::PH_DONE)
        else $error("name_last without done");

    // non-name words carry a zero byte
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !name_valid) |-> name_byte == 8'h00)
        else $error("name_byte not zero when invalid");

    // done and error are sticky
    a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == pcne_pkg::PH_DONE || phase_reg == pcne_pkg::PH_ERROR)
            |=> phase_reg == $past(phase_reg))
        else $error("terminal phase left");

endmodule

// ----- src/pcne_matcher.sv -----
module pcne_matcher
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       alt,
    input  logic       en,
    input  logic       clr,
    input  logic [7:0] byte_in,
    output logic       hit
);

    logic [pcne_pkg::POS_W-1:0] pos_reg;
    logic [pcne_pkg::POS_W-1:0] pos_next;
    logic [pcne_pkg::POS_W:0]   pos_inc;
    logic                       miss;

    // compare the byte at the current position
    assign miss    = pcne_pkg::HDR_CARE[pos_reg]
                     && (pcne_pkg::hdr_byte(alt, pos_reg) != byte_in);
    assign pos_inc = {1'b0, pos_reg} + {{pcne_pkg::POS_W{1'b0}}, 1'b1};
    assign hit     = en && !miss
                     && (pos_inc >= pcne_pkg::HEADER_LEN[pcne_pkg::POS_W:0]);

    // advance, drop to zero on a mismatch, clear on any header found
    always_comb
    begin
        pos_next = pos_reg;
        if (en)
        begin
            if (miss || hit || clr)
                pos_next = '0;
            else
                pos_next = pos_inc[pcne_pkg::POS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

endmodule
